FILE: hdl/flow_pulse_period_averager_top_macros.svh
// Assertion macros for the flow pulse period averager.
// Included by the top level; no other dependencies.
`ifndef FLOW_PULSE_PERIOD_AVERAGER_TOP_MACROS_SVH
`define FLOW_PULSE_PERIOD_AVERAGER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fppa: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FPPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fppa: next-cycle check failed");

`endif

FILE: hdl/fppa_pkg.sv
// Shared widths, constants and register codes for the flow pulse period averager.
// No dependencies.
`timescale 1ns / 1ps

package fppa_pkg;

    localparam int PER_W   = 16;   // period and counter width, ms
    localparam int DEB_W   = 8;
    localparam int GAIN_W  = 24;
    localparam int FREQ_W  = 26;
    localparam int RATE_W  = 30;
    localparam int Q_FRAC  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int DEF_AVG_DEPTH = 20;

    localparam logic [PER_W-1:0]  CNT_MAX      = 16'hFFFF;
    localparam logic [FREQ_W-1:0] FREQ_MAX_Q16 = 26'd65536000; // 1000 Hz in Q16.16
    localparam logic [RATE_W-1:0] RATE_MAX_Q16 = 30'h3FFFFFFF;

    localparam logic [DEB_W-1:0]  RST_DEBOUNCE = 8'd5;
    localparam logic [PER_W-1:0]  RST_TIMEOUT  = 16'd1000;
    localparam logic [PER_W-1:0]  RST_INIT_PER = 16'd1200;
    localparam logic [GAIN_W-1:0] RST_GAIN     = 24'd252062;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_INIT_PER = 2'd2,
        CFG_GAIN     = 2'd3
    } t_cfg_idx;

endpackage

FILE: hdl/fppa_tick_if.sv
// Input channel: one millisecond tick item with the meter edge flag.
// Depends on fppa_pkg.
`timescale 1ns / 1ps

interface fppa_tick_if import fppa_pkg::*; ();
    logic valid;
    logic ready;
    logic pulse_edge;

    modport source (output valid, output pulse_edge, input ready);
    modport sink   (input valid, input pulse_edge, output ready);
endinterface

FILE: hdl/fppa_reading_if.sv
// Output channel: one frequency and flow rate reading item.
// Depends on fppa_pkg.
`timescale 1ns / 1ps

interface fppa_reading_if import fppa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_q16;
    logic [RATE_W-1:0] rate_q16;
    logic              timed_out;

    modport source (output valid, output freq_q16, output rate_q16, output timed_out,
                    input ready);
    modport sink   (input valid, input freq_q16, input rate_q16, input timed_out,
                    output ready);
endinterface

FILE: hdl/fppa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fppa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: hdl/fppa_muldiv.sv
// Serial divide then multiply on one shared add/subtract unit:
// freq = AVG_DEPTH*1000*2^16 / sum, rate = freq*gain >> 16, both saturated.
// Depends on fppa_pkg.
`timescale 1ns / 1ps

module fppa_muldiv import fppa_pkg::*; #(
    parameter int AVG_DEPTH = DEF_AVG_DEPTH,
    localparam int SUM_W = PER_W + $clog2(AVG_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_done,
    output logic [FREQ_W-1:0] o_freq,
    output logic [RATE_W-1:0] o_rate
);
    localparam int NUM_W  = FREQ_W + $clog2(AVG_DEPTH);
    localparam int LO_W   = (NUM_W > GAIN_W) ? NUM_W : GAIN_W;
    localparam int ACC_W  = (SUM_W > FREQ_W) ? SUM_W : FREQ_W;
    localparam int ADD_W  = ACC_W + 1;
    localparam int CNT_W  = $clog2(LO_W);
    localparam int PH_W   = FREQ_W + GAIN_W - Q_FRAC;
    localparam logic [63:0] NUM_FULL = 64'(AVG_DEPTH) * 64'(FREQ_MAX_Q16);
    localparam logic [NUM_W-1:0] NUM = NUM_W'(NUM_FULL);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_DIV  = 5'b00010,
        M_SAT  = 5'b00100,
        M_MUL  = 5'b01000,
        M_FIN  = 5'b10000
    } t_md_state;

    t_md_state         r_state, n_state;
    logic [ACC_W-1:0]  r_acc;
    logic [LO_W-1:0]   r_lo;
    logic [CNT_W-1:0]  r_cnt;
    logic [FREQ_W-1:0] r_freq;
    logic [RATE_W-1:0] r_rate;
    logic              r_done;

    // shared add/subtract unit
    logic [ADD_W-1:0]  a_op, b_op;
    logic              sub_op;
    logic [ADD_W:0]    alu_s;
    logic [SUM_W:0]    div_t;
    logic              div_ge;
    logic [NUM_W-1:0]  quot;
    logic [FREQ_W-1:0] freq_sat;
    logic [PH_W-1:0]   prod_hi;

    always_comb begin
        div_t  = {r_acc[SUM_W-1:0], r_lo[LO_W-1]};
        a_op   = '0;
        b_op   = '0;
        sub_op = 1'b0;
        case (r_state)
            M_DIV: begin
                a_op   = ADD_W'(div_t);
                b_op   = ADD_W'(i_sum);
                sub_op = 1'b1;
            end
            M_MUL: begin
                a_op = ADD_W'(r_acc[FREQ_W-1:0]);
                b_op = r_lo[0] ? ADD_W'(r_freq) : '0;
            end
            default: begin
                a_op = '0;
            end
        endcase
        alu_s  = {1'b0, a_op} + {1'b0, (sub_op ? ~b_op : b_op)} + (ADD_W+1)'(sub_op);
        div_ge = alu_s[ADD_W];
    end

    always_comb begin
        quot = r_lo[NUM_W-1:0];
        if (i_sum == '0) begin
            freq_sat = '0;
        end else if (quot > NUM_W'(FREQ_MAX_Q16)) begin
            freq_sat = FREQ_MAX_Q16;
        end else begin
            freq_sat = quot[FREQ_W-1:0];
        end
        prod_hi = {r_acc[FREQ_W-1:0], r_lo[GAIN_W-1:Q_FRAC]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_start) n_state = M_DIV;
            M_DIV:   if (r_cnt == '0) n_state = M_SAT;
            M_SAT:   n_state = M_MUL;
            M_MUL:   if (r_cnt == '0) n_state = M_FIN;
            M_FIN:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_acc <= '0;
                r_lo  <= LO_W'(NUM);
                r_cnt <= CNT_W'(NUM_W - 1);
            end
            M_DIV: begin
                // shift in one numerator bit, keep the difference when it fits
                r_acc <= div_ge ? ACC_W'(alu_s[SUM_W-1:0]) : ACC_W'(div_t[SUM_W-1:0]);
                r_lo  <= {r_lo[LO_W-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            M_SAT: begin
                r_freq <= freq_sat;
                r_acc  <= '0;
                r_lo   <= LO_W'(i_gain);
                r_cnt  <= CNT_W'(GAIN_W - 1);
            end
            M_MUL: begin
                r_acc <= ACC_W'(alu_s[FREQ_W:1]);
                r_lo  <= LO_W'({alu_s[0], r_lo[GAIN_W-1:1]});
                r_cnt <= r_cnt - 1'b1;
            end
            M_FIN: begin
                r_rate <= (prod_hi > PH_W'(RATE_MAX_Q16)) ? RATE_MAX_Q16
                                                           : prod_hi[RATE_W-1:0];
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_freq = r_freq;
    assign o_rate = r_rate;
endmodule

FILE: hdl/flow_pulse_period_averager_top.sv
// Flow pulse period averager. Each input item is one millisecond tick; an item
// that carries no accepted edge is taken while ready stays high, and a tick that
// raises a timeout reading holds ready low while the block waits in S_EMIT for
// the reading to move to the output register. An item with an accepted edge
// holds ready low through S_UPD, S_CALC, S_WAIT and S_EMIT: the ring and sum
// are updated, then the bit-serial divide and multiply run on the shared
// add/subtract unit; a full output register holds the block in S_EMIT until
// the reading is taken. The period ring lives in a RAM whose entries read as
// the initial period until rewritten, so no clearing pass is needed after reset.
// Depends on fppa_pkg, fppa_tick_if, fppa_reading_if, fppa_ram, fppa_muldiv.
`timescale 1ns / 1ps

module flow_pulse_period_averager_top import fppa_pkg::*; #(
    parameter int AVG_DEPTH = DEF_AVG_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fppa_tick_if.sink             i_tick,
    fppa_reading_if.source        o_reading,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    `include "flow_pulse_period_averager_top_macros.svh"

    localparam int SUM_W = PER_W + $clog2(AVG_DEPTH);
    localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_CALC = 5'b00100,
        S_WAIT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [DEB_W-1:0]  r_debounce;
    logic [PER_W-1:0]  r_timeout;
    logic [PER_W-1:0]  r_init;
    logic [GAIN_W-1:0] r_gain;
    logic [PTR_W-1:0]  r_ptr;
    logic [AVG_DEPTH-1:0] r_vld;
    logic [SUM_W-1:0]  r_sum;
    logic [PER_W-1:0]  r_since, r_idle;
    logic [PER_W-1:0]  r_period;
    logic              r_start;
    logic [FREQ_W-1:0] r_res_freq;
    logic [RATE_W-1:0] r_res_rate;
    logic              r_res_to;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_freq;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_out_to;

    logic              tick_acc, edge_ok, idle_due, out_free;
    logic              edge_take, cnt_clear, emit_go;
    logic [PER_W-1:0]  since_inc, idle_inc;
    logic [PER_W-1:0]  ram_rd, old_per;
    logic [SUM_W-1:0]  n_sum;
    logic [PTR_W-1:0]  ptr_next;
    logic              md_done;
    logic [FREQ_W-1:0] md_freq;
    logic [RATE_W-1:0] md_rate;

    assign i_tick.ready = (r_state == S_IDLE);
    assign tick_acc     = i_tick.valid && (r_state == S_IDLE);
    assign since_inc    = (r_since == CNT_MAX) ? r_since : r_since + 1'b1;
    assign idle_inc     = (r_idle == CNT_MAX) ? r_idle : r_idle + 1'b1;
    assign edge_ok      = i_tick.pulse_edge && (since_inc > PER_W'(r_debounce));
    assign idle_due     = (idle_inc >= r_timeout);
    assign out_free     = !r_out_valid || o_reading.ready;
    assign old_per      = r_vld[r_ptr] ? ram_rd : r_init;
    assign n_sum        = r_sum - SUM_W'(old_per) + SUM_W'(r_period);
    assign ptr_next     = (r_ptr == PTR_W'(AVG_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
    assign edge_take    = tick_acc && edge_ok;
    assign cnt_clear    = (r_since == '0) && (r_idle == '0);
    assign emit_go      = (r_state == S_EMIT) && out_free;

    fppa_ram #(
        .WIDTH (PER_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_ptr),
        .i_wr_data (r_period),
        .i_rd_en   (edge_take),
        .i_rd_addr (r_ptr),
        .o_rd_data (ram_rd)
    );

    fppa_muldiv #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_sum   (r_sum),
        .i_gain  (r_gain),
        .o_done  (md_done),
        .o_freq  (md_freq),
        .o_rate  (md_rate)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_acc && edge_ok) begin
                    n_state = S_UPD;
                end else if (tick_acc && idle_due) begin
                    n_state = S_EMIT;
                end
            end
            S_UPD:   n_state = S_CALC;
            S_CALC:  if (md_done) n_state = S_WAIT;
            S_WAIT:  n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_debounce  <= RST_DEBOUNCE;
            r_timeout   <= RST_TIMEOUT;
            r_init      <= RST_INIT_PER;
            r_gain      <= RST_GAIN;
            r_ptr       <= '0;
            r_vld       <= '0;
            r_sum       <= SUM_W'(AVG_DEPTH * RST_INIT_PER);
            r_since     <= '0;
            r_idle      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_UPD);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data[DEB_W-1:0];
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[PER_W-1:0];
                    CFG_INIT_PER: begin
                        // refill the ring: drop every written entry
                        r_init <= i_cfg_data[PER_W-1:0];
                        r_vld  <= '0;
                        r_sum  <= SUM_W'(SUM_W'(AVG_DEPTH) * SUM_W'(i_cfg_data[PER_W-1:0]));
                    end
                    CFG_GAIN:     r_gain <= i_cfg_data[GAIN_W-1:0];
                    default:      r_gain <= r_gain;
                endcase
            end
            if (tick_acc) begin
                if (edge_ok) begin
                    r_since <= '0;
                    r_idle  <= '0;
                end else begin
                    r_since <= since_inc;
                    r_idle  <= idle_due ? '0 : idle_inc;
                end
            end
            if (r_state == S_UPD) begin
                r_sum        <= n_sum;
                r_vld[r_ptr] <= 1'b1;
                r_ptr        <= ptr_next;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_reading.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_period   <= since_inc;
            r_res_freq <= '0;
            r_res_rate <= '0;
            r_res_to   <= !edge_ok;
        end
        if (r_state == S_CALC && md_done) begin
            r_res_freq <= md_freq;
            r_res_rate <= md_rate;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_freq <= r_res_freq;
            r_out_rate <= r_res_rate;
            r_out_to   <= r_res_to;
        end
    end

    assign o_reading.valid     = r_out_valid;
    assign o_reading.freq_q16  = r_out_freq;
    assign o_reading.rate_q16  = r_out_rate;
    assign o_reading.timed_out = r_out_to;

    `FPPA_ASSERT_NOW(a_done_in_calc, i_clk, i_rst_n, md_done, r_state == S_CALC)
    `FPPA_ASSERT_NEXT(a_edge_clears, i_clk, i_rst_n, edge_take, (r_state == S_UPD) && cnt_clear)
    `FPPA_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1, r_ptr <= PTR_W'(AVG_DEPTH - 1))
    `FPPA_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, emit_go, r_out_valid && (r_state == S_IDLE))
endmodule
